// File: design/xfr_pkg.sv
// Shared types, codes and the CRC-16 byte update for the XMODEM frame receiver.
`timescale 1ns / 1ps

package xfr_pkg;

  localparam logic [7:0]  SOH_BYTE = 8'h01;
  localparam logic [7:0]  STX_BYTE = 8'h02;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic REG_CRC_MODE = 1'b0;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_BAD_CHECK = 3'd2,
    KIND_BAD_NUM   = 3'd3,
    KIND_TIMEOUT   = 3'd4,
    KIND_CONTROL   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] block_number;
    logic       long_frame;
  } result_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/xmodem_frame_receiver.sv
// Top level of the XMODEM / 1K-XMODEM frame receiver with its APB mode register.
//
// Input channel: one line byte (line_byte_i) or a timeout tick (timed_out_i)
// per transfer, in_valid_i / in_stall_o. Output channel: kind_o, data_byte_o,
// block_number_o, long_frame_o per transfer, out_valid_o / out_stall_i.
// SOH opens a SHORT_PAYLOAD frame, STX a LONG_PAYLOAD frame; other idle bytes
// come out as control bytes. Each payload byte is passed out as it arrives,
// and the check byte(s) end the frame with one verdict.
// Throughput: one input transfer per cycle while in_stall_o is low; all parsing,
// the CRC-16 byte update and the sum are combinational between the frame state
// registers and the result register. A result is registered in the output
// register, or in the skid stage while the output stalls. Number, complement,
// frame-start and first CRC bytes produce no result.
// When the receiver stalls, one further result is caught in a skid stage;
// in_stall_o rises only while that stage is occupied.
// Reset leaves the parser idle, the output empty and crc_mode at 1 (CRC-16).
// Users write crc_mode (address 0) over APB only while idle; unchecked by the block.
`timescale 1ns / 1ps

module xmodem_frame_receiver import xfr_pkg::*; #(
  parameter int SHORT_PAYLOAD = 128,
  parameter int LONG_PAYLOAD  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  line_byte_i,
  input  logic        timed_out_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  block_number_o,
  output logic        long_frame_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic    crc_mode_q;
  logic    in_fire;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t out;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CRC_MODE) begin
      crc_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_CRC_MODE) ? {31'd0, crc_mode_q} : 32'd0;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  xfr_fsm #(
    .SHORT_PAYLOAD(SHORT_PAYLOAD),
    .LONG_PAYLOAD (LONG_PAYLOAD)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .line_byte_i(line_byte_i),
    .timed_out_i(timed_out_i),
    .crc_mode_i (crc_mode_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  xfr_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out)
  );

  assign kind_o         = out.kind;
  assign data_byte_o    = out.data_byte;
  assign block_number_o = out.block_number;
  assign long_frame_o   = out.long_frame;

endmodule

// File: design/xfr_fsm.sv
// Frame parser: phase tracking, running checks and per-byte result decode.
`timescale 1ns / 1ps

module xfr_fsm import xfr_pkg::*; #(
  parameter int SHORT_PAYLOAD = 128,
  parameter int LONG_PAYLOAD  = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [7:0] line_byte_i,
  input  logic       timed_out_i,
  input  logic       crc_mode_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int MaxPay = (SHORT_PAYLOAD > LONG_PAYLOAD) ? SHORT_PAYLOAD : LONG_PAYLOAD;
  localparam int CntW   = $clog2(MaxPay + 1);
  localparam logic [CntW-1:0] ShortSize = CntW'(SHORT_PAYLOAD);
  localparam logic [CntW-1:0] LongSize  = CntW'(LONG_PAYLOAD);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_NUMBER  = 3'd1,
    PH_COMPL   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK1  = 3'd4,
    PH_CHECK2  = 3'd5
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            is_long_q, is_long_d;
  logic [7:0]      number_q, number_d;
  logic [7:0]      compl_q, compl_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      crc_high_q, crc_high_d;

  logic [CntW-1:0] frame_size;
  logic [CntW-1:0] count_inc;
  logic            check_ok;
  logic            emit;
  result_t         res;

  assign frame_size = is_long_q ? LongSize : ShortSize;
  assign count_inc  = byte_count_q + CntW'(1);

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    is_long_d    = is_long_q;
    number_d     = number_q;
    compl_d      = compl_q;
    crc_d        = crc_q;
    sum_d        = sum_q;
    crc_high_d   = crc_high_q;
    emit         = 1'b0;
    check_ok     = 1'b0;
    res          = '{kind: KIND_DATA, data_byte: 8'h00, block_number: number_q,
                     long_frame: is_long_q};

    if (phase_q == PH_IDLE) begin
      if (!timed_out_i) begin
        if (line_byte_i == SOH_BYTE || line_byte_i == STX_BYTE) begin
          is_long_d    = (line_byte_i == STX_BYTE);
          phase_d      = PH_NUMBER;
          byte_count_d = '0;
          number_d     = '0;
          compl_d      = '0;
          crc_d        = '0;
          sum_d        = '0;
          crc_high_d   = '0;
        end else begin
          emit = 1'b1;
          res  = '{kind: KIND_CONTROL, data_byte: line_byte_i, block_number: 8'h00,
                   long_frame: 1'b0};
        end
      end
    end else if (timed_out_i) begin
      emit     = 1'b1;
      res.kind = KIND_TIMEOUT;
      phase_d  = PH_IDLE;
    end else begin
      case (phase_q)
        PH_NUMBER: begin
          number_d = line_byte_i;
          phase_d  = PH_COMPL;
        end
        PH_COMPL: begin
          compl_d      = line_byte_i;
          byte_count_d = '0;
          phase_d      = (frame_size == '0) ? PH_CHECK1 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_d = crc16_update(crc_q, line_byte_i);
          sum_d = sum_q + line_byte_i;
          if (count_inc >= frame_size) begin
            byte_count_d = '0;
            phase_d      = PH_CHECK1;
          end else begin
            byte_count_d = count_inc;
          end
          emit          = 1'b1;
          res.data_byte = line_byte_i;
        end
        PH_CHECK1: begin
          if (crc_mode_i) begin
            crc_high_d = line_byte_i;
            phase_d    = PH_CHECK2;
          end else begin
            emit     = 1'b1;
            check_ok = (line_byte_i == sum_q);
            phase_d  = PH_IDLE;
          end
        end
        PH_CHECK2: begin
          emit     = 1'b1;
          check_ok = ({crc_high_q, line_byte_i} == crc_q);
          phase_d  = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      // verdict: a bad check outranks a bad block number
      if (emit && phase_q != PH_PAYLOAD) begin
        if (!check_ok) begin
          res.kind = KIND_BAD_CHECK;
        end else if (compl_q != ~number_q) begin
          res.kind = KIND_BAD_NUM;
        end else begin
          res.kind = KIND_GOOD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      byte_count_q <= '0;
      is_long_q    <= 1'b0;
      number_q     <= '0;
      compl_q      <= '0;
      crc_q        <= '0;
      sum_q        <= '0;
      crc_high_q   <= '0;
    end else if (in_fire_i) begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      is_long_q    <= is_long_d;
      number_q     <= number_d;
      compl_q      <= compl_d;
      crc_q        <= crc_d;
      sum_q        <= sum_d;
      crc_high_q   <= crc_high_d;
    end
  end

  assign res_valid_o = in_fire_i & emit;
  assign res_o       = res;

`ifndef NO_ASSERTIONS
  a_timeout_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && timed_out_i |=> phase_q == PH_IDLE)
    else $error("timeout transfer did not return to idle");

  a_data_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_DATA |-> phase_q == PH_PAYLOAD)
    else $error("payload byte emitted outside payload phase");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> byte_count_q < frame_size)
    else $error("payload byte count ran past frame size");
`endif

endmodule

// File: design/xfr_out.sv
// Result register with a skid stage so the input side never waits on a stall edge.
`timescale 1ns / 1ps

module xfr_out import xfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !skid_valid_q)
    else $error("result arrived while skid stage full");
`endif

endmodule

// File: dv/xmodem_frame_receiver_test.sv
// Self-checking testbench for the XMODEM frame receiver: directed frames, then random traffic.
`timescale 1ns / 1ps

module xmodem_frame_receiver_test;
  import xfr_pkg::*;

  localparam int SHORT_LEN     = 128;
  localparam int LONG_LEN      = 1024;
  localparam int RANDOM_ITEMS  = 60;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_NUMBER,
    PARSE_COMPL,
    PARSE_PAYLOAD,
    PARSE_CHECK_HI,
    PARSE_CHECK_LO
  } parse_state_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  line_byte_i;
  logic        timed_out_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  block_number_o;
  logic        long_frame_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // frame parser mirror
  parse_state_e rx_phase;
  int           rx_count;
  logic         rx_long;
  logic [7:0]   rx_number;
  logic [7:0]   rx_compl;
  logic [15:0]  rx_crc;
  logic [7:0]   rx_sum;
  logic [7:0]   rx_crc_hi;
  logic         mode_crc;

  result_t expected_results[$];
  int      errors;
  int      items_sent;
  bit      no_idle;

  xmodem_frame_receiver #(
    .SHORT_PAYLOAD(SHORT_LEN),
    .LONG_PAYLOAD (LONG_LEN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .line_byte_i   (line_byte_i),
    .timed_out_i   (timed_out_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .block_number_o(block_number_o),
    .long_frame_o  (long_frame_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // CRC-16/XMODEM, one input bit at a time
  function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic kind_e frame_verdict(bit check_ok);
    if (!check_ok) return KIND_BAD_CHECK;
    if (rx_compl != ~rx_number) return KIND_BAD_NUM;
    return KIND_GOOD;
  endfunction

  // Advances the parser mirror by one input transfer; returns 1 when a result is due.
  function automatic bit parse_line_byte(input logic [7:0] b, input logic tmo,
                                         output result_t r);
    r.kind         = KIND_DATA;
    r.data_byte    = 8'h00;
    r.block_number = 8'h00;
    r.long_frame   = 1'b0;
    if (rx_phase == PARSE_IDLE) begin
      if (tmo) return 1'b0;
      if (b == SOH_BYTE || b == STX_BYTE) begin
        rx_long   = (b == STX_BYTE);
        rx_phase  = PARSE_NUMBER;
        rx_count  = 0;
        rx_number = 8'h00;
        rx_compl  = 8'h00;
        rx_crc    = 16'h0000;
        rx_sum    = 8'h00;
        rx_crc_hi = 8'h00;
        return 1'b0;
      end
      r.kind      = KIND_CONTROL;
      r.data_byte = b;
      return 1'b1;
    end
    r.block_number = rx_number;
    r.long_frame   = rx_long;
    if (tmo) begin
      r.kind   = KIND_TIMEOUT;
      rx_phase = PARSE_IDLE;
      return 1'b1;
    end
    case (rx_phase)
      PARSE_NUMBER: begin
        rx_number = b;
        rx_phase  = PARSE_COMPL;
        return 1'b0;
      end
      PARSE_COMPL: begin
        rx_compl = b;
        rx_count = 0;
        rx_phase = PARSE_PAYLOAD;
        return 1'b0;
      end
      PARSE_PAYLOAD: begin
        rx_crc = crc_next(rx_crc, b);
        rx_sum = rx_sum + b;
        if (rx_count + 1 >= (rx_long ? LONG_LEN : SHORT_LEN)) begin
          rx_count = 0;
          rx_phase = PARSE_CHECK_HI;
        end else begin
          rx_count++;
        end
        r.kind      = KIND_DATA;
        r.data_byte = b;
        return 1'b1;
      end
      PARSE_CHECK_HI: begin
        // mode is taken when the first check byte arrives
        if (mode_crc) begin
          rx_crc_hi = b;
          rx_phase  = PARSE_CHECK_LO;
          return 1'b0;
        end
        r.kind   = frame_verdict(b == rx_sum);
        rx_phase = PARSE_IDLE;
        return 1'b1;
      end
      default: begin
        r.kind   = frame_verdict({rx_crc_hi, b} == rx_crc);
        rx_phase = PARSE_IDLE;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic tmo);
    int      gap;
    result_t r;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    line_byte_i <= b;
    timed_out_i <= tmo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (parse_line_byte(b, tmo, r)) expected_results.push_back(r);
    items_sent++;
  endtask

  // Sends one frame; cut_at >= 0 replaces that byte with a timeout and ends the frame there.
  task automatic send_frame(input bit long_f, input logic [7:0] num, input bit bad_check,
                            input bit bad_num, input int cut_at);
    logic [7:0]  frame_q[$];
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [7:0]  chk_hi;
    logic [7:0]  chk_lo;
    logic [15:0] crc;
    crc = 16'h0000;
    sum = 8'h00;
    frame_q.push_back(long_f ? STX_BYTE : SOH_BYTE);
    frame_q.push_back(num);
    frame_q.push_back(bad_num ? ~num ^ 8'($urandom_range(1, 255)) : ~num);
    repeat (long_f ? LONG_LEN : SHORT_LEN) begin
      b   = 8'($urandom);
      crc = crc_next(crc, b);
      sum = sum + b;
      frame_q.push_back(b);
    end
    if (mode_crc) begin
      chk_hi = crc[15:8];
      chk_lo = crc[7:0];
      if (bad_check) begin
        if ($urandom_range(0, 1)) chk_hi ^= 8'($urandom_range(1, 255));
        else chk_lo ^= 8'($urandom_range(1, 255));
      end
      frame_q.push_back(chk_hi);
      frame_q.push_back(chk_lo);
    end else begin
      frame_q.push_back(bad_check ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
    for (int i = 0; i < frame_q.size(); i++) begin
      if (i == cut_at) begin
        send_item(8'($urandom), 1'b1);
        return;
      end
      send_item(frame_q[i], 1'b0);
    end
  endtask

  // closes a half-open frame with a timeout tick
  task automatic resync();
    if (rx_phase != PARSE_IDLE) send_item(8'($urandom), 1'b1);
  endtask

  task automatic settle();
    resync();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CRC_MODE, 2'b00};
    pwdata  <= {31'b0, m};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mode_crc = m;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read back
    @(negedge clk_i);
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {31'b0, m}) begin
      $error("crc_mode readback: expected %0h, got %0h", {31'b0, m}, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_control_bytes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h04, 1'b0);  // EOT
    send_item(8'h18, 1'b0);  // CAN
    send_item(8'h06, 1'b0);
    send_item(8'h15, 1'b0);
    send_item(8'h43, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    // timeouts while idle report nothing, even with a frame-start byte on the line
    send_item(SOH_BYTE, 1'b1);
    send_item(STX_BYTE, 1'b1);
    send_item(8'hFF, 1'b1);
    settle();
  endtask

  task automatic test_frame_timeouts();
    send_frame(1'b0, 8'h00, 1'b0, 1'b0, 1);  // before the block number
    send_frame(1'b1, 8'hFF, 1'b0, 1'b0, 2);  // before the complement
    send_frame(1'b0, 8'h80, 1'b0, 1'b0, 6);  // inside the payload
    send_frame(1'b1, 8'h55, 1'b0, 1'b0, 4);
    send_item(8'h04, 1'b0);                  // back to idle
    settle();
  endtask

  task automatic test_crc_frames();
    send_frame(1'b0, 8'hFE, 1'b0, 1'b1, -1);
    send_frame(1'b0, 8'h7F, 1'b1, 1'b1, -1);  // bad check wins over bad number
    send_frame(1'b0, 8'h33, 1'b0, 1'b0, SHORT_LEN + 4);  // between the CRC bytes
    settle();
  endtask

  task automatic test_sum_frames();
    write_mode(1'b0);
    send_frame(1'b0, 8'hFF, 1'b0, 1'b0, -1);
    send_frame(1'b0, 8'h10, 1'b1, 1'b0, -1);
    send_frame(1'b0, 8'h5A, 1'b0, 1'b0, SHORT_LEN + 3);  // at the sum byte
    send_frame(1'b1, 8'hC3, 1'b0, 1'b0, 12);
    settle();
  endtask

  task automatic test_long_frames();
    write_mode(1'b1);
    send_frame(1'b1, 8'h00, 1'b0, 1'b0, -1);
    settle();
  endtask

  task automatic test_random_traffic();
    int start_count;
    int pick;
    int cut;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        settle();
        write_mode(1'($urandom_range(0, 1)));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        resync();
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SHORT_LEN + 4) : -1;
        send_frame(1'b0, 8'($urandom), $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                   cut);
      end else if (pick < 75) begin
        resync();
        send_frame(1'b1, 8'($urandom), 1'b0, 1'b0, $urandom_range(0, 40));
      end else begin
        // line noise, may open frames that then break
        repeat ($urandom_range(1, 8)) send_item(8'($urandom), $urandom_range(0, 6) == 0);
      end
    end
    no_idle = 1'b0;
    settle();
  endtask

  // receiver-side stall pattern
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat (pick_gap()) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_checker
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0h block %0h long %0b", kind_o, data_byte_o,
               block_number_o, long_frame_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          errors++;
        end
        if (data_byte_o !== want.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want.data_byte, data_byte_o);
          errors++;
        end
        if (block_number_o !== want.block_number) begin
          $error("block_number: expected %0h, got %0h", want.block_number, block_number_o);
          errors++;
        end
        if (long_frame_o !== want.long_frame) begin
          $error("long_frame: expected %0b, got %0b", want.long_frame, long_frame_o);
          errors++;
        end
      end
    end
  end

  // ends the run when neither side has a transfer for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    line_byte_i = 8'h00;
    timed_out_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 3'b000;
    pwdata      = 32'h0;
    errors      = 0;
    items_sent  = 0;
    no_idle     = 1'b0;
    mode_crc    = 1'b1;
    rx_phase    = PARSE_IDLE;
    rx_count    = 0;
    rx_long     = 1'b0;
    rx_number   = 8'h00;
    rx_compl    = 8'h00;
    rx_crc      = 16'h0000;
    rx_sum      = 8'h00;
    rx_crc_hi   = 8'h00;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_control_bytes();
    test_frame_timeouts();
    test_crc_frames();
    test_sum_frames();
    test_long_frames();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/xfr_pkg.sv
design/xfr_fsm.sv
design/xfr_out.sv
design/xmodem_frame_receiver.sv
dv/xmodem_frame_receiver_test.sv
